// File: design/smfs_pkg.sv
package smfs_pkg;

    localparam logic [3:0] SLAVES = 4'd8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CS    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_SLAVE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MODE_TABLE  = 2'd1;
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd2;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] tx_byte;
        logic [2:0] slave_index;
        logic       cs_level;
        logic       miso;
    } t_in;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic [7:0] cs_lines;
        logic [7:0] rx_byte;
        logic       byte_done;
        logic       busy_res;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [3:0]  slave_count;
        logic [15:0] mode_table;
        logic [7:0]  half_period;
    } t_cfg;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] tx_byte;
        logic [2:0] slave_index;
        logic       cs_level;
        logic       miso;
        logic       idx_ok;
        logic [1:0] mode;
        logic [7:0] half_period;
    } t_cmd;

endpackage

// File: design/smfs_front.sv
module smfs_front (
    input  smfs_pkg::t_in  i_word,
    input  smfs_pkg::t_cfg i_cfg,
    output smfs_pkg::t_cmd o_cmd
);
    import smfs_pkg::*;

    logic [3:0] lim;

    always_comb begin
        lim = (i_cfg.slave_count > SLAVES) ? SLAVES : i_cfg.slave_count;
        o_cmd.operation   = i_word.operation;
        o_cmd.tx_byte     = i_word.tx_byte;
        o_cmd.slave_index = i_word.slave_index;
        o_cmd.cs_level    = i_word.cs_level;
        o_cmd.miso        = i_word.miso;
        o_cmd.idx_ok      = ({1'b0, i_word.slave_index} < lim);
        o_cmd.mode        = i_cfg.mode_table[{i_word.slave_index, 1'b0} +: 2];
        o_cmd.half_period = (i_cfg.half_period == 8'd0) ? 8'd1 : i_cfg.half_period;
    end

endmodule

// File: design/smfs_queue.sv
module smfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  smfs_pkg::t_cmd i_cmd,
    output logic           o_stall,
    output logic           o_valid,
    output smfs_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import smfs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_head;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    logic       wr_ptr;

    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_head];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_valid;
    assign wr_ptr  = r_head ^ r_count[0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (pop) begin
                r_head <= ~r_head;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: design/smfs_back.sv
module smfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  smfs_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output smfs_pkg::t_out o_out
);
    import smfs_pkg::*;

    logic [7:0] r_tx, n_tx;
    logic [7:0] r_rx, n_rx;
    logic [3:0] r_bits, n_bits;
    logic       r_phase, n_phase;
    logic [7:0] r_ticks, n_ticks;
    logic [7:0] r_cs, n_cs;
    logic       r_clk_lvl, n_clk_lvl;
    logic       r_busy, n_busy;
    logic       r_mosi, n_mosi;
    logic [1:0] r_mode, n_mode;
    logic       r_out_valid;
    t_out       r_out;
    t_out       res;
    logic [8:0] next_tick;
    logic [3:0] bits_inc;

    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_bits    = r_bits;
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_cs      = r_cs;
        n_clk_lvl = r_clk_lvl;
        n_busy    = r_busy;
        n_mosi    = r_mosi;
        n_mode    = r_mode;
        res       = '0;
        res.status = ST_OK;
        next_tick = {1'b0, r_ticks} + 9'd1;
        bits_inc  = r_bits + 4'd1;
        if (o_pop) begin
            case (i_cmd.operation)
                OP_START: begin
                    if (r_busy) begin
                        res.status = ST_BUSY;
                    end else if (!i_cmd.idx_ok) begin
                        res.status = ST_RANGE;
                    end else begin
                        n_mode    = i_cmd.mode;
                        n_tx      = i_cmd.tx_byte;
                        n_rx      = 8'd0;
                        n_bits    = 4'd0;
                        n_phase   = 1'b0;
                        n_ticks   = 8'd0;
                        n_clk_lvl = i_cmd.mode[1];
                        n_busy    = 1'b1;
                        if (!i_cmd.mode[0]) begin
                            n_mosi = |(i_cmd.tx_byte & MSB_MASK);
                        end
                    end
                end
                OP_CS: begin
                    if (!i_cmd.idx_ok) begin
                        res.status = ST_RANGE;
                    end else begin
                        n_cs[i_cmd.slave_index] = i_cmd.cs_level;
                        if (!r_busy) begin
                            n_clk_lvl = i_cmd.mode[1];
                        end
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        if (next_tick >= {1'b0, i_cmd.half_period}) begin
                            n_ticks   = 8'd0;
                            n_clk_lvl = ~r_clk_lvl;
                            if (!r_phase) begin
                                // leading edge
                                if (r_mode[0]) begin
                                    n_mosi = |(r_tx & MSB_MASK);
                                    n_tx   = {r_tx[6:0], 1'b0};
                                end else begin
                                    n_rx = {r_rx[6:0], i_cmd.miso};
                                end
                                n_phase = 1'b1;
                            end else begin
                                // trailing edge
                                if (r_mode[0]) begin
                                    n_rx = {r_rx[6:0], i_cmd.miso};
                                end
                                n_phase = 1'b0;
                                if (bits_inc >= 4'd8) begin
                                    n_busy        = 1'b0;
                                    res.byte_done = 1'b1;
                                    res.rx_byte   = n_rx;
                                    n_bits        = 4'd0;
                                end else begin
                                    n_bits = bits_inc;
                                    if (!r_mode[0]) begin
                                        n_tx   = {r_tx[6:0], 1'b0};
                                        n_mosi = r_tx[6];
                                    end
                                end
                            end
                        end else begin
                            n_ticks = next_tick[7:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res.sclk     = n_clk_lvl;
        res.mosi     = n_mosi;
        res.cs_lines = n_cs;
        res.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx        <= 8'd0;
            r_rx        <= 8'd0;
            r_bits      <= 4'd0;
            r_phase     <= 1'b0;
            r_ticks     <= 8'd0;
            r_cs        <= 8'hFF;
            r_clk_lvl   <= 1'b0;
            r_busy      <= 1'b0;
            r_mosi      <= 1'b0;
            r_mode      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx        <= n_tx;
            r_rx        <= n_rx;
            r_bits      <= n_bits;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_cs        <= n_cs;
            r_clk_lvl   <= n_clk_lvl;
            r_busy      <= n_busy;
            r_mosi      <= n_mosi;
            r_mode      <= n_mode;
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= res;
        end
    end

endmodule

// File: design/spi_master_four_mode_shifter.sv
// channel | valid       | stall        | word
// input   | i_in_valid  | o_in_stall   | i_in  (t_in)
// result  | o_out_valid | i_out_stall  | o_out (t_out)
// config  | i_cfg_we    | -            | i_cfg_index, i_cfg_data
// One word per clock while the result is not stalled; each word passes
// through a queue slot, then the transfer engine and its result register.
// A result stall reaches the input once the two-entry queue fills.
// Reset (synchronous, i_rst_n low) empties queue and result register.
// A stalled result holds; input stalls only when the queue is full.
module spi_master_four_mode_shifter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  smfs_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output smfs_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import smfs_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_valid;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_count <= 4'd8;
            r_cfg.mode_table  <= 16'd0;
            r_cfg.half_period <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE_COUNT: r_cfg.slave_count <= i_cfg_data[3:0];
                CFG_MODE_TABLE:  r_cfg.mode_table  <= i_cfg_data;
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    smfs_front u_front (
        .i_word (i_in),
        .i_cfg  (r_cfg),
        .o_cmd  (front_cmd)
    );

    smfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_cmd   (front_cmd),
        .o_stall (o_in_stall),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    smfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.byte_done |-> !o_out.busy_res)
        else $error("byte_done while still busy");

    a_reject_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |-> !o_out.byte_done)
        else $error("rejected word reports a finished byte");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("engine took a word from an empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left result or queue occupied");
`endif

endmodule
